>>> sv/dlci_pkg.sv
// Shared types and constants for the DDA line color interpolator.
package dlci_pkg;
    localparam int TILE_SIZE_DEF = 64;
    localparam int FRAC_BITS_DEF = 16;
    localparam int LEN_W = 7;
    localparam int QDEPTH = 2;
    localparam logic [6:0] FB_WIDTH_RST = 7'd64;
    localparam logic [7:0] CH_MAX = 8'hff;

    typedef struct packed {
        logic [5:0] x0;
        logic [5:0] y0;
        logic [5:0] x1;
        logic [5:0] y1;
        logic [7:0] r0;
        logic [7:0] g0;
        logic [7:0] b0;
        logic [7:0] a0;
        logic [7:0] r1;
        logic [7:0] g1;
        logic [7:0] b1;
        logic [7:0] a1;
    } cmd_t;

    typedef struct packed {
        logic [5:0]  pix_x;
        logic [5:0]  pix_y;
        logic [11:0] pix_addr;
        logic [31:0] pix_color;
        logic        last_pixel;
    } pix_t;
endpackage

>>> sv/dlci_if.sv
// Valid/ready channel interfaces for commands, pixels and configuration.
interface dlci_cmd_if;
    logic valid;
    logic ready;
    logic [5:0] x_start;
    logic [5:0] y_start;
    logic [5:0] x_end;
    logic [5:0] y_end;
    logic [7:0] red_start;
    logic [7:0] green_start;
    logic [7:0] blue_start;
    logic [7:0] alpha_start;
    logic [7:0] red_end;
    logic [7:0] green_end;
    logic [7:0] blue_end;
    logic [7:0] alpha_end;
    modport source (output valid, x_start, y_start, x_end, y_end, red_start, green_start,
        blue_start, alpha_start, red_end, green_end, blue_end, alpha_end, input ready);
    modport sink (input valid, x_start, y_start, x_end, y_end, red_start, green_start,
        blue_start, alpha_start, red_end, green_end, blue_end, alpha_end, output ready);
endinterface

interface dlci_pix_if;
    logic valid;
    logic ready;
    logic [5:0]  pix_x;
    logic [5:0]  pix_y;
    logic [11:0] pix_addr;
    logic [31:0] pix_color;
    logic        last_pixel;
    modport source (output valid, pix_x, pix_y, pix_addr, pix_color, last_pixel,
        input ready);
    modport sink (input valid, pix_x, pix_y, pix_addr, pix_color, last_pixel,
        output ready);
endinterface

interface dlci_cfg_if;
    logic valid;
    logic ready;
    logic [6:0] data;
    modport source (output valid, data, input ready);
    modport sink (input valid, data, output ready);
endinterface

>>> sv/dda_line_color_interpolate.sv
// Top level: DDA line rasterizer with per-pixel color interpolation.
//  channel | dir | word
//  cmd     | in  | one line command (endpoints, start/end RGBA)
//  pix     | out | one pixel write (x, y, addr, color, last)
//  cfg     | in  | fb_width
// A command is popped, then runs through the shared restoring divider
// for its six quotients, then emits LEN pixels, one each cycle.
// Zero-length commands are popped and emit no pixel. A two-entry queue lets commands
// be taken while the back end works. Pixel stalls hold the DDA.
// Reset sets fb_width to 64 and empties the queue.
module dda_line_color_interpolate
#(
    parameter int TILE_SIZE = dlci_pkg::TILE_SIZE_DEF,
    parameter int FRAC_BITS = dlci_pkg::FRAC_BITS_DEF
)
(
    input logic      clk,
    input logic      rst_n,
    dlci_cmd_if.sink cmd,
    dlci_pix_if.source pix,
    dlci_cfg_if.sink cfg
);
    import dlci_pkg::*;

    cmd_t       q_data;
    logic       q_valid, q_pop, idle;
    logic [6:0] fbw_reg;

    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) fbw_reg <= FB_WIDTH_RST;
        else if (cfg.valid) fbw_reg <= cfg.data;
    end

    dlci_front #(.TILE_SIZE(TILE_SIZE)) u_front (
        .clk(clk), .rst_n(rst_n), .cmd(cmd),
        .q_data(q_data), .q_valid(q_valid), .q_pop(q_pop));

    dlci_back #(.TILE_SIZE(TILE_SIZE), .FRAC_BITS(FRAC_BITS)) u_back (
        .clk(clk), .rst_n(rst_n), .q_data(q_data), .q_valid(q_valid),
        .q_pop(q_pop), .fb_width(fbw_reg), .idle(idle), .pix(pix));

`ifndef SYNTHESIS
    a_cfg_idle: assert property (@(posedge clk) disable iff (!rst_n)
        cfg.valid |=> fbw_reg == $past(cfg.data)) else $error("cfg write lost");
    a_idle_nopix: assert property (@(posedge clk) disable iff (!rst_n)
        idle |-> !pix.valid) else $error("pixel while idle");
    a_last_alone: assert property (@(posedge clk) disable iff (!rst_n)
        (pix.valid && pix.ready && pix.last_pixel) |=> !(pix.valid && idle))
        else $error("bad idle after last");
`endif
endmodule

>>> sv/dlci_front.sv
// Front end: accepts line commands, clamps coordinates, queues them.
module dlci_front
#(
    parameter int TILE_SIZE = dlci_pkg::TILE_SIZE_DEF
)
(
    input  logic           clk,
    input  logic           rst_n,
    dlci_cmd_if.sink       cmd,
    output dlci_pkg::cmd_t q_data,
    output logic           q_valid,
    input  logic           q_pop
);
    import dlci_pkg::*;

    localparam logic [5:0] CMAX = 6'(TILE_SIZE - 1);

    cmd_t       mem [QDEPTH];
    logic       wp_reg, wp_next, rp_reg, rp_next;
    logic [1:0] cnt_reg, cnt_next;
    cmd_t       c;
    logic       push;

    function automatic logic [5:0] clampc(input logic [5:0] v);
        return (v > CMAX) ? CMAX : v;
    endfunction

    assign cmd.ready = (cnt_reg != 2'(QDEPTH));
    assign push      = cmd.valid && cmd.ready;
    assign q_valid   = (cnt_reg != 2'd0);
    assign q_data    = mem[rp_reg];

    always_comb
    begin
        c.x0 = clampc(cmd.x_start);
        c.y0 = clampc(cmd.y_start);
        c.x1 = clampc(cmd.x_end);
        c.y1 = clampc(cmd.y_end);
        c.r0 = cmd.red_start;
        c.g0 = cmd.green_start;
        c.b0 = cmd.blue_start;
        c.a0 = cmd.alpha_start;
        c.r1 = cmd.red_end;
        c.g1 = cmd.green_end;
        c.b1 = cmd.blue_end;
        c.a1 = cmd.alpha_end;
        wp_next  = push ? ~wp_reg : wp_reg;
        rp_next  = q_pop ? ~rp_reg : rp_reg;
        cnt_next = cnt_reg + 2'(push) - 2'(q_pop);
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wp_reg] <= c;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg  <= 1'b0;
            rp_reg  <= 1'b0;
            cnt_reg <= 2'd0;
        end
        else
        begin
            wp_reg  <= wp_next;
            rp_reg  <= rp_next;
            cnt_reg <= cnt_next;
        end
    end

`ifndef SYNTHESIS
    a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |-> q_valid) else $error("pop from empty queue");
    a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= 2'(QDEPTH)) else $error("queue overflow");
    a_full_block: assert property (@(posedge clk) disable iff (!rst_n)
        (cnt_reg == 2'(QDEPTH)) |-> !cmd.ready) else $error("ready while full");
`endif
endmodule

>>> sv/dlci_back.sv
// Back end: restoring divider for the steps, then one pixel per cycle unless the pixel output stalls.
module dlci_back
#(
    parameter int TILE_SIZE = dlci_pkg::TILE_SIZE_DEF,
    parameter int FRAC_BITS = dlci_pkg::FRAC_BITS_DEF
)
(
    input  logic           clk,
    input  logic           rst_n,
    input  dlci_pkg::cmd_t q_data,
    input  logic           q_valid,
    output logic           q_pop,
    input  logic [6:0]     fb_width,
    output logic           idle,
    dlci_pix_if.source     pix
);
    import dlci_pkg::*;

    localparam int NW = 9 + FRAC_BITS;   // |delta|<<F magnitude
    localparam int AW = 10 + FRAC_BITS;  // signed accumulator
    localparam int NQ = 6;               // 2 position + 4 color quotients
    localparam int CW = $clog2(NW + 1);
    localparam logic [5:0] CMAX = 6'(TILE_SIZE - 1);

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_DIV  = 3'b010,
        S_RUN  = 3'b100
    } state_t;

    state_t state_reg, state_next;
    logic [CW-1:0] bit_reg, bit_next;
    logic [2:0]    qi_reg, qi_next;
    logic [LEN_W-1:0] len_reg, left_reg, left_next;
    logic [8:0]    dmag_reg [NQ];
    logic          dneg_reg [NQ];
    logic [NW-1:0] rem_reg, quo_reg;
    logic signed [AW-1:0] acc_reg [NQ];
    logic signed [AW-1:0] stp_reg [NQ];
    logic          ovalid_reg;
    pix_t          opix_reg;
    logic [NW-1:0] rem_sh, rem_sub;
    logic          ge;
    logic signed [9:0] delta [NQ];
    logic [5:0] ax, ay;
    logic [7:0] ch [4];
    logic [11:0] addr;
    logic        out_free;
    logic        emit;

    function automatic logic [7:0] afloor(input logic signed [AW-1:0] a, input logic [7:0] hi);
        logic [AW-1:0] v;
        v = AW'(a) >> FRAC_BITS;
        if (a < 0) return 8'd0;
        return (v > AW'(hi)) ? hi : v[7:0];
    endfunction

    always_comb
    begin
        delta[0] = 10'(q_data.x1) - 10'(q_data.x0);
        delta[1] = 10'(q_data.y1) - 10'(q_data.y0);
        delta[2] = 10'(q_data.r1) - 10'(q_data.r0);
        delta[3] = 10'(q_data.g1) - 10'(q_data.g0);
        delta[4] = 10'(q_data.b1) - 10'(q_data.b0);
        delta[5] = 10'(q_data.a1) - 10'(q_data.a0);
    end

    assign ax = delta[0][9] ? 6'(-delta[0]) : delta[0][5:0];
    assign ay = delta[1][9] ? 6'(-delta[1]) : delta[1][5:0];

    // one quotient bit a cycle; dividend is |delta| << FRAC_BITS
    logic [NW-1:0] num;
    assign num     = NW'(dmag_reg[qi_reg]) << FRAC_BITS;
    assign rem_sh  = {rem_reg[NW-2:0], num[bit_reg - CW'(1)]};
    assign ge      = rem_sh >= NW'(len_reg);
    assign rem_sub = ge ? rem_sh - NW'(len_reg) : rem_sh;

    assign out_free = !ovalid_reg || pix.ready;
    assign emit     = (state_reg == S_RUN) && out_free;
    assign idle     = (state_reg == S_IDLE) && !ovalid_reg && !q_valid;
    assign q_pop    = (state_reg == S_IDLE) && q_valid;

    always_comb
    begin
        ch[0] = afloor(acc_reg[2], CH_MAX);
        ch[1] = afloor(acc_reg[3], CH_MAX);
        ch[2] = afloor(acc_reg[4], CH_MAX);
        ch[3] = afloor(acc_reg[5], CH_MAX);
    end
    logic [5:0] px, py;
    assign px   = 6'(afloor(acc_reg[0], 8'(CMAX)));
    assign py   = 6'(afloor(acc_reg[1], 8'(CMAX)));
    assign addr = 12'(13'(py) * 13'(fb_width)) + 12'(px);

    always_comb
    begin
        state_next = state_reg;
        bit_next   = bit_reg;
        qi_next    = qi_reg;
        left_next  = left_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (q_valid)
                begin
                    left_next = (ax > ay) ? 7'(ax) : 7'(ay);
                    bit_next  = CW'(NW);
                    qi_next   = 3'd0;
                    if (left_next != '0) state_next = S_DIV;
                end
            end
            S_DIV:
            begin
                bit_next = bit_reg - CW'(1);
                if (bit_reg == CW'(1))
                begin
                    bit_next = CW'(NW);
                    qi_next  = qi_reg + 3'd1;
                    if (qi_reg == 3'(NQ - 1)) state_next = S_RUN;
                end
            end
            S_RUN:
            begin
                if (emit)
                begin
                    left_next = left_reg - 7'd1;
                    if (left_reg == 7'd1) state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (q_pop)
        begin
            len_reg <= left_next;
            rem_reg <= '0;
            acc_reg[0] <= AW'(q_data.x0) <<< FRAC_BITS;
            acc_reg[1] <= AW'(q_data.y0) <<< FRAC_BITS;
            acc_reg[2] <= AW'(q_data.r0) <<< FRAC_BITS;
            acc_reg[3] <= AW'(q_data.g0) <<< FRAC_BITS;
            acc_reg[4] <= AW'(q_data.b0) <<< FRAC_BITS;
            acc_reg[5] <= AW'(q_data.a0) <<< FRAC_BITS;
            for (int i = 0; i < NQ; i++)
            begin
                dneg_reg[i] <= delta[i][9];
                dmag_reg[i] <= delta[i][9] ? 9'(-delta[i]) : delta[i][8:0];
            end
        end
        if (state_reg == S_DIV)
        begin
            if (bit_reg == CW'(1))
            begin
                rem_reg <= '0;
                stp_reg[qi_reg] <= dneg_reg[qi_reg]
                    ? -$signed(AW'({quo_reg[NW-2:0], ge}))
                    : $signed(AW'({quo_reg[NW-2:0], ge}));
            end
            else
            begin
                rem_reg <= rem_sub;
            end
            quo_reg <= {quo_reg[NW-2:0], ge};
        end
        if (emit)
        begin
            for (int i = 0; i < NQ; i++) acc_reg[i] <= acc_reg[i] + stp_reg[i];
            opix_reg.pix_x      <= px;
            opix_reg.pix_y      <= py;
            opix_reg.pix_addr   <= addr;
            opix_reg.pix_color  <= {ch[3], ch[0], ch[1], ch[2]};
            opix_reg.last_pixel <= (left_reg == 7'd1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            bit_reg    <= '0;
            qi_reg     <= '0;
            left_reg   <= '0;
            ovalid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            bit_reg   <= bit_next;
            qi_reg    <= qi_next;
            left_reg  <= left_next;
            if (emit) ovalid_reg <= 1'b1;
            else if (pix.ready) ovalid_reg <= 1'b0;
        end
    end

    assign pix.valid      = ovalid_reg;
    assign pix.pix_x      = opix_reg.pix_x;
    assign pix.pix_y      = opix_reg.pix_y;
    assign pix.pix_addr   = opix_reg.pix_addr;
    assign pix.pix_color  = opix_reg.pix_color;
    assign pix.last_pixel = opix_reg.last_pixel;

`ifndef SYNTHESIS
    a_run_left: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_RUN) |-> (left_reg != '0)) else $error("run with no pixels");
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (ovalid_reg && !pix.ready) |=> ovalid_reg && $stable(opix_reg))
        else $error("stalled pixel changed");
    a_pop_idle: assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |-> (state_reg == S_IDLE)) else $error("pop while busy");
`endif
endmodule

>>> verif/tb_dda_line_color_interpolate.sv
// Testbench for the DDA line color interpolator: directed table plus random lines.
module tb_dda_line_color_interpolate;
    import dlci_pkg::*;

    localparam int FB = 16;
    localparam int CMD_DRAIN = 200;

    typedef struct {
        cmd_t   cmd;
        bit     has_first;
        pix_t   first;
    } vec_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    bit   failed = 1'b0;
    int   sender_idle_pct = 0;
    int   stall_pct = 0;
    bit   check_first = 1'b0;
    pix_t first_pix;

    logic [6:0] width_q = FB_WIDTH_RST;
    pix_t       pixel_q[$];

    dlci_cmd_if cmd_ch();
    dlci_pix_if pix_ch();
    dlci_cfg_if cfg_ch();

    dda_line_color_interpolate i_dut
    (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (cmd_ch.sink),
        .pix   (pix_ch.source),
        .cfg   (cfg_ch.sink)
    );

    always #5 clk = ~clk;

    initial
    begin
        #50_000_000;
        $display("TEST FAILED");
        $finish;
    end

    function automatic logic [7:0] floor_clamp(longint acc, int hi);
        longint v;
        if (acc < 0)
            return 8'd0;
        v = acc >>> FB;
        return (v > hi) ? hi[7:0] : v[7:0];
    endfunction

    // Expand one line command into its pixel words.
    function automatic void rasterize(cmd_t c);
        longint len, dx, dy;
        longint px_acc, py_acc, sx, sy;
        longint col_acc[4], col_step[4];
        logic [7:0] c0[4], c1[4];
        logic [7:0] fx, fy, r, g, b, a;
        pix_t p;
        c0 = '{c.r0, c.g0, c.b0, c.a0};
        c1 = '{c.r1, c.g1, c.b1, c.a1};
        dx = longint'(c.x1) - longint'(c.x0);
        dy = longint'(c.y1) - longint'(c.y0);
        len = ((dx < 0) ? -dx : dx) > ((dy < 0) ? -dy : dy) ?
              ((dx < 0) ? -dx : dx) : ((dy < 0) ? -dy : dy);
        if (len == 0)
            return;
        px_acc = longint'(c.x0) <<< FB;
        py_acc = longint'(c.y0) <<< FB;
        sx = (dx <<< FB) / len;
        sy = (dy <<< FB) / len;
        for (int ch = 0; ch < 4; ch++)
        begin
            col_acc[ch] = longint'(c0[ch]) <<< FB;
            col_step[ch] = ((longint'(c1[ch]) - longint'(c0[ch])) <<< FB) / len;
        end
        for (longint n = len; n > 0; n--)
        begin
            fx = floor_clamp(px_acc, 63);
            fy = floor_clamp(py_acc, 63);
            r = floor_clamp(col_acc[0], 255);
            g = floor_clamp(col_acc[1], 255);
            b = floor_clamp(col_acc[2], 255);
            a = floor_clamp(col_acc[3], 255);
            p.pix_x = fx[5:0];
            p.pix_y = fy[5:0];
            p.pix_addr = 12'(int'(fy) * int'(width_q) + int'(fx));
            p.pix_color = {a, r, g, b};
            p.last_pixel = (n == 1);
            pixel_q.push_back(p);
            px_acc += sx;
            py_acc += sy;
            for (int ch = 0; ch < 4; ch++)
                col_acc[ch] += col_step[ch];
        end
    endfunction

    // Pixel side: random stall and in-order compare.
    initial
    begin
        pix_ch.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (pix_ch.valid === 1'b1 && pix_ch.ready === 1'b1)
            begin
                pix_t got;
                pix_t exp_p;
                got = '{pix_ch.pix_x, pix_ch.pix_y, pix_ch.pix_addr, pix_ch.pix_color,
                        pix_ch.last_pixel};
                if (pixel_q.size() == 0)
                begin
                    $display("%0t unexpected pixel %p", $time, got);
                    failed = 1'b1;
                end
                else
                begin
                    exp_p = pixel_q.pop_front();
                    if (check_first && got != first_pix)
                    begin
                        $display("%0t table mismatch exp %p got %p", $time, first_pix, got);
                        failed = 1'b1;
                    end
                    check_first = 1'b0;
                    if (got.pix_x != exp_p.pix_x || got.pix_y != exp_p.pix_y ||
                        got.pix_addr != exp_p.pix_addr ||
                        got.pix_color != exp_p.pix_color ||
                        got.last_pixel != exp_p.last_pixel)
                    begin
                        $display("%0t pixel mismatch exp %p got %p", $time, exp_p, got);
                        failed = 1'b1;
                    end
                end
            end
            pix_ch.ready <= ($urandom_range(99) >= stall_pct);
        end
    end

    // valid stays high after the accept so back-to-back words need no gap;
    // an idle gap or drain() drops it
    task automatic send_line(cmd_t c);
        if ($urandom_range(99) < sender_idle_pct)
        begin
            cmd_ch.valid <= 1'b0;
            do
                @(posedge clk);
            while ($urandom_range(99) < sender_idle_pct);
        end
        cmd_ch.valid <= 1'b1;
        {cmd_ch.x_start, cmd_ch.y_start, cmd_ch.x_end, cmd_ch.y_end,
         cmd_ch.red_start, cmd_ch.green_start, cmd_ch.blue_start, cmd_ch.alpha_start,
         cmd_ch.red_end, cmd_ch.green_end, cmd_ch.blue_end, cmd_ch.alpha_end} <= c;
        do
            @(posedge clk);
        while (cmd_ch.ready !== 1'b1);
        rasterize(c);
    endtask

    task automatic drain();
        cmd_ch.valid <= 1'b0;
        while (pixel_q.size() != 0)
            @(posedge clk);
        repeat (CMD_DRAIN * 3) @(posedge clk);
    endtask

    task automatic set_width(logic [6:0] w);
        drain();
        cfg_ch.valid <= 1'b1;
        cfg_ch.data <= w;
        do
            @(posedge clk);
        while (cfg_ch.ready !== 1'b1);
        cfg_ch.valid <= 1'b0;
        width_q = w;
    endtask

    function automatic cmd_t rand_line();
        cmd_t c;
        c = cmd_t'({$urandom, $urandom, $urandom});
        // mostly short lines, some long ones
        if ($urandom_range(3) != 0)
        begin
            c.x1 = 6'(int'(c.x0) + $urandom_range(8) - 4);
            c.y1 = 6'(int'(c.y0) + $urandom_range(8) - 4);
        end
        return c;
    endfunction

    vec_t table_v[$];

    initial
    begin
        cmd_t c;
        cmd_ch.valid <= 1'b0;
        {cmd_ch.x_start, cmd_ch.y_start, cmd_ch.x_end, cmd_ch.y_end,
         cmd_ch.red_start, cmd_ch.green_start, cmd_ch.blue_start, cmd_ch.alpha_start,
         cmd_ch.red_end, cmd_ch.green_end, cmd_ch.blue_end, cmd_ch.alpha_end} <= '0;
        cfg_ch.valid <= 1'b0;
        cfg_ch.data <= '0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // first pixel is the start point with the start color
        table_v.push_back('{'{0, 0, 63, 63, 0, 0, 0, 0, 255, 255, 255, 255}, 1,
                            '{0, 0, 0, 32'h0, 1'b0}});
        table_v.push_back('{'{63, 63, 0, 0, 255, 255, 255, 255, 0, 0, 0, 0}, 1,
                            '{63, 63, 12'd4095, 32'hffffffff, 1'b0}});
        table_v.push_back('{'{5, 5, 5, 5, 1, 2, 3, 4, 5, 6, 7, 8}, 0, '{default: 0}});
        table_v.push_back('{'{10, 3, 11, 3, 8'h12, 8'h34, 8'h56, 8'h78, 0, 0, 0, 0}, 1,
                            '{10, 3, 12'd202, 32'h78123456, 1'b1}});
        table_v.push_back('{'{0, 63, 63, 0, 255, 0, 255, 0, 0, 255, 0, 255}, 0, '{default: 0}});
        table_v.push_back('{'{63, 0, 0, 63, 0, 128, 7, 200, 255, 1, 250, 3}, 0, '{default: 0}});
        table_v.push_back('{'{20, 20, 20, 40, 10, 20, 30, 40, 11, 19, 31, 39}, 0, '{default: 0}});
        table_v.push_back('{'{20, 40, 20, 20, 0, 0, 0, 0, 1, 1, 1, 1}, 0, '{default: 0}});
        table_v.push_back('{'{30, 30, 33, 37, 255, 255, 255, 255, 254, 0, 128, 255}, 0,
                            '{default: 0}});
        table_v.push_back('{'{1, 2, 0, 0, 100, 100, 100, 100, 100, 100, 100, 100}, 0,
                            '{default: 0}});

        foreach (table_v[i])
        begin
            if (table_v[i].has_first)
            begin
                drain();
                first_pix = table_v[i].first;
                check_first = 1'b1;
            end
            send_line(table_v[i].cmd);
        end

        set_width(7'd1);
        send_line('{2, 60, 9, 50, 0, 9, 99, 250, 255, 0, 3, 1});
        set_width(7'd0);
        send_line('{0, 0, 6, 63, 1, 2, 3, 4, 9, 8, 7, 6});
        set_width(7'd127);
        send_line('{63, 63, 40, 20, 5, 5, 5, 5, 6, 6, 6, 6});
        set_width(7'd64);

        for (int phase = 0; phase < 4; phase++)
        begin
            sender_idle_pct = (phase == 1 || phase == 3) ? ((phase == 3) ? 37 : 80) : 0;
            stall_pct = (phase == 2 || phase == 3) ? ((phase == 3) ? 37 : 80) : 0;
            for (int n = 0; n < 50; n++)
            begin
                c = rand_line();
                send_line(c);
            end
            sender_idle_pct = 0;
            stall_pct = 0;
            set_width((phase == 0) ? 7'd33 : 7'($urandom_range(1, 64)));
        end

        fork
            drain();
            begin
                #40_000_000;
            end
        join_any
        if (!failed && pixel_q.size() == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end
endmodule
